@@ rtl/twcw_pkg.sv @@
package twcw_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 32;

    localparam int CELL_W     = 16;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR  = 2'd3;

    localparam logic [7:0] WIDTH_COLS_RST  = 8'd80;
    localparam logic [5:0] HEIGHT_ROWS_RST = 6'd25;
    localparam logic [3:0] TEXT_COLOR_RST  = 4'd15;
    localparam logic [3:0] BACK_COLOR_RST  = 4'd0;

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_SETCUR  = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_CLRLINE = 3'd3;
    localparam logic [2:0] OP_SCROLL  = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

endpackage

@@ rtl/text_window_cell_writer.sv @@
// Handles set cursor, write char, read cell (a read outside the window returns zeros),
// clear, clear line and scroll by n.
// A newline or wrap on the bottom row scrolls the window up by one row.
// One item at a time: in_stall stays high until the result loads.
// Cell store is a single-port-write RAM; every cell moved or blanked is a RAM write.
// After reset a clearing pass zeroes all MAX_COLS*MAX_ROWS cells (4096 by default).
module text_window_cell_writer
    import twcw_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            op,
    input  logic [7:0]            char_code,
    input  logic [6:0]            col,
    input  logic [4:0]            row,
    input  logic [4:0]            count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            cursor_col,
    output logic [4:0]            cursor_row,
    output logic [7:0]            cell_char,
    output logic [7:0]            cell_attr
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COLW1  = $clog2(MAX_COLS + 1);
    localparam int ROWW1  = $clog2(MAX_ROWS + 1);

    typedef enum logic [13:0] {
        S_INIT = 14'h0001,
        S_IDLE = 14'h0002,
        S_DISP = 14'h0004,
        S_WR1  = 14'h0008,
        S_WR2  = 14'h0010,
        S_CLN  = 14'h0020,
        S_SC1  = 14'h0040,
        S_SC2  = 14'h0080,
        S_CPRD = 14'h0100,
        S_CPWR = 14'h0200,
        S_FILL = 14'h0400,
        S_RD   = 14'h0800,
        S_RDW  = 14'h1000,
        S_DONE = 14'h2000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    logic [ROWW1-1:0]  n_reg, n_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic              out_valid_reg;
    logic [6:0]        out_col_reg;
    logic [4:0]        out_row_reg;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_attr_reg;

    logic [7:0]        width_cols_reg;
    logic [5:0]        height_rows_reg;
    logic [3:0]        text_color_reg;
    logic [3:0]        back_color_reg;

    logic [2:0]        op_reg;
    logic [7:0]        char_reg;
    logic [6:0]        col_in_reg;
    logic [4:0]        row_in_reg;
    logic [4:0]        cnt_reg;

    logic [COLW1-1:0]  w_eff;
    logic [ROWW1-1:0]  h_eff;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [COL_W-1:0]  cur_col_cl, set_col;
    logic [ROW_W-1:0]  cur_row_cl, set_row;
    logic [ROWW1-1:0]  n_cl;
    logic              rd_ok, cln_ok, row_last, do_adv, out_load;
    logic [7:0]        attr;
    logic [CELL_W-1:0] blank;

    logic [ROWW1-1:0]       mul_a;
    logic [ROWW1+COLW1-1:0] mul_full;
    logic [CNT_W-1:0]       mul_p;
    logic [CNT_W-1:0]       wr_base, rd_base, src_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    twcw_cell_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (width_cols_reg == '0)
        begin
            w_eff = COLW1'(1);
        end
        else if (32'(width_cols_reg) > MAX_COLS)
        begin
            w_eff = COLW1'(MAX_COLS);
        end
        else
        begin
            w_eff = COLW1'(width_cols_reg);
        end
        if (height_rows_reg == '0)
        begin
            h_eff = ROWW1'(1);
        end
        else if (32'(height_rows_reg) > MAX_ROWS)
        begin
            h_eff = ROWW1'(MAX_ROWS);
        end
        else
        begin
            h_eff = ROWW1'(height_rows_reg);
        end
    end

    assign w_m1 = COL_W'(w_eff - 1'b1);
    assign h_m1 = ROW_W'(h_eff - 1'b1);

    assign cur_col_cl = (32'(cur_col_reg) > 32'(w_m1)) ? w_m1 : cur_col_reg;
    assign cur_row_cl = (32'(cur_row_reg) > 32'(h_m1)) ? h_m1 : cur_row_reg;
    assign set_col    = (32'(col_in_reg) > 32'(w_m1)) ? w_m1 : COL_W'(col_in_reg);
    assign set_row    = (32'(row_in_reg) > 32'(h_m1)) ? h_m1 : ROW_W'(row_in_reg);
    assign n_cl       = (32'(cnt_reg) > 32'(h_eff)) ? h_eff : ROWW1'(cnt_reg);
    assign rd_ok      = (32'(col_in_reg) < 32'(w_eff)) && (32'(row_in_reg) < 32'(h_eff));
    assign cln_ok     = 32'(cnt_reg) < 32'(h_eff);
    assign row_last   = cur_row_reg == h_m1;

    assign attr  = {back_color_reg, text_color_reg};
    assign blank = {attr, 8'h00};

    // shared row-times-width multiplier
    assign mul_full = mul_a * w_eff;
    assign mul_p    = CNT_W'(mul_full);

    assign wr_base  = idx_reg + CNT_W'(cur_col_reg);
    assign rd_base  = idx_reg + CNT_W'(col_in_reg);
    assign src_addr = idx_reg + off_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        off_next      = off_reg;
        n_next        = n_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        mul_a         = '0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[ADDR_W-1:0];
        ram_wdata     = blank;
        ram_raddr     = idx_reg[ADDR_W-1:0];
        do_adv        = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (idx_reg == CNT_W'(DEPTH - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_col_next  = cur_col_cl;
                    cur_row_next  = cur_row_cl;
                    res_char_next = '0;
                    res_attr_next = '0;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                case (op_reg)
                    OP_WRITE:
                    begin
                        if (char_reg == CH_NUL)
                        begin
                            state_next = S_DONE;
                        end
                        else if (char_reg == CH_NEWLINE)
                        begin
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            mul_a      = ROWW1'(cur_row_reg);
                            idx_next   = mul_p;
                            state_next = S_WR1;
                        end
                    end
                    OP_SETCUR:
                    begin
                        cur_col_next = set_col;
                        cur_row_next = set_row;
                        state_next   = S_DONE;
                    end
                    OP_CLEAR:
                    begin
                        mul_a      = h_eff;
                        end_next   = mul_p;
                        idx_next   = '0;
                        state_next = S_FILL;
                    end
                    OP_CLRLINE:
                    begin
                        if (cln_ok)
                        begin
                            mul_a      = ROWW1'(cnt_reg);
                            idx_next   = mul_p;
                            state_next = S_CLN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_SCROLL:
                    begin
                        if (n_cl == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            n_next     = n_cl;
                            state_next = S_SC1;
                        end
                    end
                    OP_READ:
                    begin
                        if (rd_ok)
                        begin
                            mul_a      = ROWW1'(row_in_reg);
                            idx_next   = mul_p;
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_base[ADDR_W-1:0];
                ram_wdata = (char_reg == CH_TAB) ? blank : {attr, char_reg};
                if (32'(cur_col_reg) + 32'd1 < 32'(w_eff))
                begin
                    if (char_reg == CH_TAB)
                    begin
                        state_next = S_WR2;
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + 1'b1;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            S_WR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(wr_base + 1'b1);
                if (32'(cur_col_reg) + 32'd2 < 32'(w_eff))
                begin
                    cur_col_next = COL_W'(cur_col_reg + 2'd2);
                    state_next   = S_DONE;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            S_CLN:
            begin
                end_next   = idx_reg + CNT_W'(w_eff);
                state_next = S_FILL;
            end
            S_SC1:
            begin
                mul_a      = n_reg;
                off_next   = mul_p;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                mul_a      = h_eff;
                end_next   = mul_p;
                idx_next   = '0;
                state_next = (n_reg == h_eff) ? S_FILL : S_CPRD;
            end
            S_CPRD:
            begin
                ram_raddr  = src_addr[ADDR_W-1:0];
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
                if (src_addr + 1'b1 == end_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_CPRD;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (idx_reg + 1'b1 == end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RD:
            begin
                ram_raddr  = rd_base[ADDR_W-1:0];
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_char_next = ram_rdata[7:0];
                res_attr_next = ram_rdata[15:8];
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // newline or wrap: bottom row scrolls by one
        if (do_adv)
        begin
            cur_col_next = '0;
            if (row_last)
            begin
                n_next     = ROWW1'(1);
                state_next = S_SC1;
            end
            else
            begin
                cur_row_next = cur_row_reg + 1'b1;
                state_next   = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            idx_reg         <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            out_valid_reg   <= 1'b0;
            width_cols_reg  <= WIDTH_COLS_RST;
            height_rows_reg <= HEIGHT_ROWS_RST;
            text_color_reg  <= TEXT_COLOR_RST;
            back_color_reg  <= BACK_COLOR_RST;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH_COLS:  width_cols_reg  <= cfg_wdata;
                    CFG_HEIGHT_ROWS: height_rows_reg <= cfg_wdata[5:0];
                    CFG_TEXT_COLOR:  text_color_reg  <= cfg_wdata[3:0];
                    CFG_BACK_COLOR:  back_color_reg  <= cfg_wdata[3:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg      <= end_next;
        off_reg      <= off_next;
        n_reg        <= n_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg     <= op;
            char_reg   <= char_code;
            col_in_reg <= col;
            row_in_reg <= row;
            cnt_reg    <= count;
        end
        if (out_load)
        begin
            out_col_reg  <= 7'(cur_col_reg);
            out_row_reg  <= 5'(cur_row_reg);
            out_char_reg <= res_char_reg;
            out_attr_reg <= res_attr_reg;
        end
    end

    assign in_stall   = state_reg != S_IDLE;
    assign out_valid  = out_valid_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;

    a_cursor_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |->
            (32'(cur_col_reg) < 32'(w_eff)) && (32'(cur_row_reg) < 32'(h_eff)))
        else $error("cursor outside window at result");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> idx_reg < end_reg)
        else $error("blank fill past end of range");

    a_copy_src_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CPRD |-> src_addr < end_reg)
        else $error("scroll source past window");

    a_cell_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (op_reg != OP_READ) |->
            (res_char_reg == '0) && (res_attr_reg == '0))
        else $error("cell data on a non-read result");

endmodule

@@ rtl/twcw_cell_ram.sv @@
module twcw_cell_ram
    import twcw_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import twcw_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int unsigned STORE_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int unsigned STALL_LIMIT = 50000;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] c;
        logic [4:0] r;
        logic [4:0] n;
    } console_cmd_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } cursor_report_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [2:0]            op = '0;
    logic [7:0]            char_code = '0;
    logic [6:0]            col = '0;
    logic [4:0]            row = '0;
    logic [4:0]            count = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [6:0]            cursor_col;
    logic [4:0]            cursor_row;
    logic [7:0]            cell_char;
    logic [7:0]            cell_attr;

    logic [15:0]    screen_cells [0:STORE_CELLS-1];
    int unsigned    cur_c;
    int unsigned    cur_r;
    logic [7:0]     width_reg;
    logic [5:0]     height_reg;
    logic [3:0]     fg_reg;
    logic [3:0]     bg_reg;
    cursor_report_t pending_reports [$];
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    mismatch_count = 0;
    int unsigned    quiet_cycles = 0;

    text_window_cell_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .count      (count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_COLS_DEF)
            return MAX_COLS_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return height_reg;
    endfunction

    function automatic logic [15:0] blank_cell();
        return {bg_reg, fg_reg, 8'h00};
    endfunction

    task automatic scroll_window(input int unsigned n, input int unsigned w,
                                 input int unsigned h);
        int unsigned keep;
        int unsigned lines;
        lines = (n > h) ? h : n;
        if (lines != 0)
        begin
            keep = (h - lines) * w;
            for (int unsigned i = 0; i < keep; i++)
                screen_cells[i] = screen_cells[i + lines * w];
            for (int unsigned i = keep; i < h * w; i++)
                screen_cells[i] = blank_cell();
        end
    endtask

    task automatic put_char(input logic [7:0] ch, input int unsigned w,
                            input int unsigned h);
        int unsigned base;
        base = cur_r * w + cur_c;
        if (ch != CH_NUL)
        begin
            if (ch == CH_NEWLINE)
            begin
                cur_r++;
                cur_c = 0;
            end
            else if (ch == CH_TAB)
            begin
                screen_cells[base] = blank_cell();
                if (cur_c + 1 < w)
                    screen_cells[base + 1] = blank_cell();
                cur_c += 2;
            end
            else
            begin
                screen_cells[base] = blank_cell() | {8'h00, ch};
                cur_c++;
            end
            if (cur_c >= w)
            begin
                cur_r++;
                cur_c = 0;
            end
            if (cur_r >= h)
            begin
                cur_r = h - 1;
                cur_c = 0;
                scroll_window(1, w, h);
            end
        end
    endtask

    task automatic window_apply(input console_cmd_t cmd, output cursor_report_t rep);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        rep = '0;
        if (cur_c > w - 1)
            cur_c = w - 1;
        if (cur_r > h - 1)
            cur_r = h - 1;
        case (cmd.op)
            OP_WRITE:
                put_char(cmd.ch, w, h);
            OP_SETCUR:
            begin
                cur_c = (cmd.c > w - 1) ? w - 1 : cmd.c;
                cur_r = (cmd.r > h - 1) ? h - 1 : cmd.r;
            end
            OP_CLEAR:
                for (int unsigned i = 0; i < w * h; i++)
                    screen_cells[i] = blank_cell();
            OP_CLRLINE:
                if (cmd.n < h)
                    for (int unsigned i = 0; i < w; i++)
                        screen_cells[cmd.n * w + i] = blank_cell();
            OP_SCROLL:
                scroll_window(cmd.n, w, h);
            OP_READ:
                if (cmd.c < w && cmd.r < h)
                begin
                    rep.cell_char = screen_cells[cmd.r * w + cmd.c][7:0];
                    rep.cell_attr = screen_cells[cmd.r * w + cmd.c][15:8];
                end
            default:
                ;
        endcase
        rep.cursor_col = cur_c[6:0];
        rep.cursor_row = cur_r[4:0];
    endtask

    function automatic console_cmd_t cmd_of(input logic [2:0] o, input logic [7:0] ch,
                                            input logic [6:0] c, input logic [4:0] r,
                                            input logic [4:0] n);
        console_cmd_t cmd;
        cmd.op = o;
        cmd.ch = ch;
        cmd.c = c;
        cmd.r = r;
        cmd.n = n;
        return cmd;
    endfunction

    // roomy: large window, keep to cheap ops so scrolls stay rare
    function automatic console_cmd_t random_cmd(input bit roomy);
        console_cmd_t cmd;
        int unsigned  pick;
        int unsigned  cpick;
        int unsigned  w;
        int unsigned  h;
        w = eff_width();
        h = eff_height();
        cmd.op = OP_WRITE;
        cmd.ch = 8'($urandom_range(126, 32));
        cmd.c = 7'($urandom);
        cmd.r = 5'($urandom);
        cmd.n = ($urandom_range(1, 0) == 0) ? 5'($urandom_range(h - 1, 0)) : 5'($urandom);
        pick = roomy ? $urandom_range(79, 0) : $urandom_range(99, 0);
        cpick = $urandom_range(99, 0);
        if (pick < 45)
        begin
            if (cpick >= 60 && cpick < 70)
                cmd.ch = roomy ? 8'h4e : CH_NEWLINE;
            else if (cpick >= 70 && cpick < 78)
                cmd.ch = CH_TAB;
            else if (cpick >= 78 && cpick < 82)
                cmd.ch = CH_NUL;
            else if (cpick >= 82)
            begin
                cmd.ch = 8'($urandom);
                if (roomy && cmd.ch == CH_NEWLINE)
                    cmd.ch = 8'hff;
            end
        end
        else if (pick < 70)
        begin
            cmd.op = OP_READ;
            if (cpick < 80)
            begin
                cmd.c = 7'($urandom_range(w - 1, 0));
                cmd.r = 5'($urandom_range(h - 1, 0));
            end
        end
        else if (pick < 80)
            cmd.op = OP_SETCUR;
        else if (pick < 86)
            cmd.op = OP_CLRLINE;
        else if (pick < 92)
            cmd.op = OP_SCROLL;
        else if (pick < 95)
            cmd.op = OP_CLEAR;
        else
            cmd.op = ($urandom_range(1, 0) == 0) ? OP_SPARE_A : OP_SPARE_B;
        return cmd;
    endfunction

    task automatic issue_cmd(input console_cmd_t cmd);
        cursor_report_t rep;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op <= cmd.op;
        char_code <= cmd.ch;
        col <= cmd.c;
        row <= cmd.r;
        count <= cmd.n;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        window_apply(cmd, rep);
        pending_reports.push_back(rep);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WIDTH_COLS:  width_reg = val;
            CFG_HEIGHT_ROWS: height_reg = val[5:0];
            CFG_TEXT_COLOR:  fg_reg = val[3:0];
            CFG_BACK_COLOR:  bg_reg = val[3:0];
            default:         ;
        endcase
    endtask

    task automatic set_window(input logic [7:0] w, input logic [7:0] h,
                              input logic [7:0] fg, input logic [7:0] bg);
        write_reg(CFG_WIDTH_COLS, w);
        write_reg(CFG_HEIGHT_ROWS, h);
        write_reg(CFG_TEXT_COLOR, fg);
        write_reg(CFG_BACK_COLOR, bg);
    endtask

    task automatic wait_all_reported();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed();
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, 8'h41, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, 8'hff, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, CH_NUL, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, CH_TAB, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, CH_NEWLINE, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_SETCUR, 8'h00, 7'd0, 5'd6, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, 8'h51, 7'd0, 5'd0, 5'd0));
        // tab in the last column: second blank cell falls off the row
        issue_cmd(cmd_of(OP_SETCUR, 8'h00, 7'd79, 5'd5, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, CH_TAB, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd79, 5'd5, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd0, 5'd6, 5'd0));
        issue_cmd(cmd_of(OP_SETCUR, 8'h00, 7'd127, 5'd31, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, 8'h5a, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd100, 5'd3, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd5, 5'd30, 5'd0));
        issue_cmd(cmd_of(OP_SPARE_A, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_SPARE_B, 8'hff, 7'd127, 5'd31, 5'd31));
        issue_cmd(cmd_of(OP_CLRLINE, 8'h00, 7'd0, 5'd0, 5'd5));
        issue_cmd(cmd_of(OP_CLRLINE, 8'h00, 7'd0, 5'd0, 5'd31));
        issue_cmd(cmd_of(OP_SCROLL, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_SCROLL, 8'h00, 7'd0, 5'd0, 5'd2));
        issue_cmd(cmd_of(OP_SCROLL, 8'h00, 7'd0, 5'd0, 5'd31));
        issue_cmd(cmd_of(OP_CLEAR, 8'h00, 7'd0, 5'd0, 5'd0));
    endtask

    // cursor left outside the window after it shrinks
    task automatic test_shrink_cursor();
        issue_cmd(cmd_of(OP_SETCUR, 8'h00, 7'd70, 5'd20, 5'd0));
        wait_all_reported();
        set_window(8'd10, 8'd5, 8'd3, 8'd12);
        issue_cmd(cmd_of(OP_SPARE_A, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_WRITE, 8'h78, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_READ, 8'h00, 7'd9, 5'd3, 5'd0));
    endtask

    task automatic test_extremes();
        wait_all_reported();
        set_window(8'd0, 8'd0, 8'd0, 8'd0);
        repeat (20) issue_cmd(random_cmd(1'b0));
        wait_all_reported();
        set_window(8'd1, 8'd1, 8'd15, 8'd15);
        repeat (20) issue_cmd(random_cmd(1'b0));
        wait_all_reported();
        set_window(8'd128, 8'd32, 8'd5, 8'd10);
        repeat (30) issue_cmd(random_cmd(1'b1));
        wait_all_reported();
        set_window(8'd255, 8'd63, 8'd10, 8'd5);
        issue_cmd(cmd_of(OP_CLEAR, 8'h00, 7'd0, 5'd0, 5'd0));
        issue_cmd(cmd_of(OP_SCROLL, 8'h00, 7'd0, 5'd0, 5'd1));
        repeat (10) issue_cmd(random_cmd(1'b1));
    endtask

    task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
        logic [7:0] w;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (4)
        begin
            wait_all_reported();
            w = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(40, 17))
                                            : 8'($urandom_range(16, 1));
            set_window(w, 8'($urandom_range(8, 1)), 8'($urandom_range(15, 0)),
                       8'($urandom_range(15, 0)));
            repeat (75) issue_cmd(random_cmd(1'b0));
        end
    endtask

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cursor_report_t exp_rep;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected result transfer: cursor %0d,%0d cell %0d attr %0d",
                         $time, cursor_col, cursor_row, cell_char, cell_attr);
                mismatch_count++;
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                check_field("cursor_col", exp_rep.cursor_col, cursor_col);
                check_field("cursor_row", exp_rep.cursor_row, cursor_row);
                check_field("cell_char", exp_rep.cell_char, cell_char);
                check_field("cell_attr", exp_rep.cell_attr, cell_attr);
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t timeout: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int unsigned i = 0; i < STORE_CELLS; i++)
            screen_cells[i] = '0;
        cur_c = 0;
        cur_r = 0;
        width_reg = WIDTH_COLS_RST;
        height_reg = HEIGHT_ROWS_RST;
        fg_reg = TEXT_COLOR_RST;
        bg_reg = BACK_COLOR_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_shrink_cursor();
        test_extremes();
        test_random_phase(0, 0);
        test_random_phase(50, 0);
        test_random_phase(0, 50);
        test_random_phase(37, 37);
        wait_all_reported();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
